// File: hdl/gisa_pkg.sv
// Shared types, constants and helpers for the grouped id slot allocator.
// No dependencies; the top level, the probe and the checker use this package.
`timescale 1ns / 1ps

package gisa_pkg;

    localparam int GROUPS_DEF    = 8;
    localparam int MAX_SLOTS_DEF = 256;

    localparam int GROUP_W  = 3;
    localparam int ID_W     = 8;
    localparam int SLOTS_W  = 9;
    localparam int COUNT_W  = 9;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_MAPPED = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_RANGE  = 2'd3
    } status_t;

    // Request and result payloads.
    typedef struct packed {
        logic [GROUP_W-1:0] group;
        logic [ID_W-1:0]    internal_id;
    } in_t;

    typedef struct packed {
        logic [ID_W-1:0] external_id;
        status_t         status;
    } out_t;

    // Forward / reverse map entry; all zero is the empty marker.
    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] value;
    } entry_t;

    // Per-group state word.
    typedef struct packed {
        logic [ID_W-1:0]    free_ptr;
        logic [COUNT_W-1:0] used;
    } grp_t;

    // Probe sequencer status toward the control FSM.
    typedef struct packed {
        logic            done;
        logic            found;
        logic [ID_W-1:0] slot;
    } probe_res_t;

    // Circular successor of a slot index, wrapping at the active slot count.
    function automatic logic [ID_W-1:0] wrap_next(input logic [ID_W-1:0] p,
                                                  input logic [SLOTS_W-1:0] slots);
        logic [SLOTS_W-1:0] n;
        n = SLOTS_W'(p) + SLOTS_W'(1);
        wrap_next = (n >= slots) ? '0 : n[ID_W-1:0];
    endfunction

endpackage

// File: hdl/grouped_id_slot_allocator.sv
// Top level of the grouped id slot allocator: control FSM, maps, group state.
// Depends on gisa_pkg, gisa_ram and gisa_probe.
`timescale 1ns / 1ps

// Usage
//   s_valid/s_ready/s_data : allocation request {group, internal_id}.
//   m_valid/m_ready/m_data : one result per request {external_id, status}.
//   cfg_valid/cfg_ready/cfg_data : slots_in_use write, always ready; clamped
//     to 1..MAX_SLOTS. Write it only while no request is in flight.
// Timing
//   Forward map, reverse map and per-group state live in RAMs with a
//   registered read port. A request does a lookup, then probes the reverse
//   map one slot per cycle: once to confirm the free pointer and, unless the
//   group is then full, once after the write to move the pointer to the next
//   empty slot, skipping occupied slots. Errors are found in the lookup or
//   the first probe. A new request is taken only once the last has a result.
//   Range errors are decided at accept, with no lookup.
// Reset
//   aresetn (sync, active low) starts a clearing pass that writes the empty
//   marker to every map entry (GROUPS*MAX_SLOTS, 2048 by default) and zeroes
//   group state, with s_ready low. Config writes are taken meanwhile.
// Back-pressure
//   The result sits in an output register. If it is not taken, the next
//   request is still accepted and worked; its result parks in a holding
//   register and s_ready stays low until the output register frees up.
module grouped_id_slot_allocator #(
    parameter int GROUPS    = gisa_pkg::GROUPS_DEF,
    parameter int MAX_SLOTS = gisa_pkg::MAX_SLOTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  gisa_pkg::in_t                 s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output gisa_pkg::out_t                m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gisa_pkg::SLOTS_W-1:0]  cfg_data
);

    localparam int DEPTH = GROUPS * MAX_SLOTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int GA    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int ENT_W = $bits(gisa_pkg::entry_t);
    localparam int GRP_W = $bits(gisa_pkg::grp_t);

    typedef enum logic [5:0] {
        ST_CLEAR   = 6'b000001,
        ST_IDLE    = 6'b000010,
        ST_LOOKUP  = 6'b000100,
        ST_SEARCH1 = 6'b001000,
        ST_SEARCH2 = 6'b010000,
        ST_HOLD    = 6'b100000
    } state_t;

    // Flat map address: group row plus slot / id within the row.
    function automatic logic [AW-1:0] row_addr(input logic [gisa_pkg::GROUP_W-1:0] g,
                                               input logic [gisa_pkg::ID_W-1:0] idx);
        row_addr = AW'(AW'(g) * AW'(MAX_SLOTS)) + AW'(idx);
    endfunction

    function automatic logic [gisa_pkg::SLOTS_W-1:0] clamp_slots(
        input logic [gisa_pkg::SLOTS_W-1:0] v);
        if (v == '0) begin
            clamp_slots = gisa_pkg::SLOTS_W'(1);
        end else if (int'(v) > MAX_SLOTS) begin
            clamp_slots = gisa_pkg::SLOTS_W'(MAX_SLOTS);
        end else begin
            clamp_slots = v;
        end
    endfunction

    state_t                          state_reg, state_next;
    logic [AW-1:0]                   clr_cnt_reg, clr_cnt_next;
    logic [gisa_pkg::SLOTS_W-1:0]    slots_reg;
    gisa_pkg::in_t                   req_reg, req_next;
    logic [gisa_pkg::ID_W-1:0]       slot_reg, slot_next;
    logic [gisa_pkg::COUNT_W-1:0]    cnt_reg, cnt_next;
    gisa_pkg::out_t                  res_reg, res_next;
    logic                            m_valid_reg, m_valid_next;
    gisa_pkg::out_t                  m_data_reg, m_data_next;

    // Memory ports.
    logic                  fwd_we, rev_we, grp_we;
    logic [AW-1:0]         fwd_waddr, fwd_raddr, rev_waddr, rev_raddr;
    logic [GA-1:0]         grp_waddr, grp_raddr;
    gisa_pkg::entry_t      fwd_wdata, rev_wdata, fwd_entry, rev_entry;
    gisa_pkg::grp_t        grp_wdata, grp_word;
    logic [ENT_W-1:0]      fwd_rdata, rev_rdata;
    logic [GRP_W-1:0]      grp_rdata;

    // Probe sequencer.
    logic                          pr_start;
    logic [gisa_pkg::ID_W-1:0]     pr_start_p, probe_idx;
    gisa_pkg::probe_res_t          pr;

    logic            in_range, out_free, fin_valid;
    gisa_pkg::out_t  fin_data;

    assign fwd_entry = gisa_pkg::entry_t'(fwd_rdata);
    assign rev_entry = gisa_pkg::entry_t'(rev_rdata);
    assign grp_word  = gisa_pkg::grp_t'(grp_rdata);

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_free  = !m_valid_reg || m_ready;

    assign in_range = (7'(s_data.group) < 7'(GROUPS)) &&
                      (gisa_pkg::SLOTS_W'(s_data.internal_id) < slots_reg);

    // Lookups are issued at accept; the probe owns the reverse read port.
    assign fwd_raddr = row_addr(s_data.group, s_data.internal_id);
    assign grp_raddr = GA'(s_data.group);
    assign rev_raddr = row_addr(req_reg.group, probe_idx);

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        req_next     = req_reg;
        slot_next    = slot_reg;
        cnt_next     = cnt_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        fwd_we    = 1'b0;
        fwd_waddr = row_addr(req_reg.group, req_reg.internal_id);
        fwd_wdata = '{valid: 1'b1, value: pr.slot};
        rev_we    = 1'b0;
        rev_waddr = row_addr(req_reg.group, pr.slot);
        rev_wdata = '{valid: 1'b1, value: req_reg.internal_id};
        grp_we    = 1'b0;
        grp_waddr = GA'(req_reg.group);
        grp_wdata = '{free_ptr: slot_reg, used: cnt_reg};

        pr_start   = 1'b0;
        pr_start_p = gisa_pkg::wrap_next(pr.slot, slots_reg);

        fin_valid = 1'b0;
        fin_data  = '{external_id: '0, status: gisa_pkg::STAT_OK};

        unique case (state_reg)
            ST_CLEAR: begin
                fwd_we    = 1'b1;
                fwd_waddr = clr_cnt_reg;
                fwd_wdata = '0;
                rev_we    = 1'b1;
                rev_waddr = clr_cnt_reg;
                rev_wdata = '0;
                grp_we    = (clr_cnt_reg < AW'(GROUPS));
                grp_waddr = GA'(clr_cnt_reg);
                grp_wdata = '0;
                if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + AW'(1);
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    req_next = s_data;
                    if (in_range) begin
                        state_next = ST_LOOKUP;
                    end else begin
                        fin_valid       = 1'b1;
                        fin_data.status = gisa_pkg::STAT_RANGE;
                    end
                end
            end
            ST_LOOKUP: begin
                // Check order: already mapped, then full count, then probe.
                if (fwd_entry.valid) begin
                    fin_valid       = 1'b1;
                    fin_data.status = gisa_pkg::STAT_MAPPED;
                end else if (gisa_pkg::SLOTS_W'(grp_word.used) >= slots_reg) begin
                    fin_valid       = 1'b1;
                    fin_data.status = gisa_pkg::STAT_FULL;
                end else begin
                    pr_start   = 1'b1;
                    // stale pointer restarts at slot 0
                    pr_start_p = (gisa_pkg::SLOTS_W'(grp_word.free_ptr) < slots_reg) ?
                                 grp_word.free_ptr : '0;
                    cnt_next   = grp_word.used + gisa_pkg::COUNT_W'(1);
                    state_next = ST_SEARCH1;
                end
            end
            ST_SEARCH1: begin
                if (pr.done) begin
                    if (pr.found) begin
                        fwd_we    = 1'b1;
                        rev_we    = 1'b1;
                        slot_next = pr.slot;
                        if (gisa_pkg::SLOTS_W'(cnt_reg) < slots_reg) begin
                            // reverse write and next probe hit different slots
                            pr_start   = 1'b1;
                            state_next = ST_SEARCH2;
                        end else begin
                            grp_we              = 1'b1;
                            grp_wdata.free_ptr  = pr.slot;
                            fin_valid           = 1'b1;
                            fin_data.external_id = pr.slot;
                        end
                    end else begin
                        fin_valid       = 1'b1;
                        fin_data.status = gisa_pkg::STAT_FULL;
                    end
                end
            end
            ST_SEARCH2: begin
                if (pr.done) begin
                    grp_we               = 1'b1;
                    grp_wdata.free_ptr   = pr.found ? pr.slot : slot_reg;
                    fin_valid            = 1'b1;
                    fin_data.external_id = slot_reg;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = state_reg;
            end
        endcase

        // Result goes straight to the output register when it is free.
        if (fin_valid) begin
            if (out_free) begin
                m_valid_next = 1'b1;
                m_data_next  = fin_data;
                state_next   = ST_IDLE;
            end else begin
                res_next   = fin_data;
                state_next = ST_HOLD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            slots_reg   <= clamp_slots(gisa_pkg::SLOTS_W'(256));
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                slots_reg <= clamp_slots(cfg_data);
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        slot_reg   <= slot_next;
        cnt_reg    <= cnt_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    gisa_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_fwd_map (
        .aclk  (aclk),
        .we    (fwd_we),
        .waddr (fwd_waddr),
        .wdata (fwd_wdata),
        .raddr (fwd_raddr),
        .rdata (fwd_rdata)
    );

    gisa_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_rev_map (
        .aclk  (aclk),
        .we    (rev_we),
        .waddr (rev_waddr),
        .wdata (rev_wdata),
        .raddr (rev_raddr),
        .rdata (rev_rdata)
    );

    gisa_ram #(
        .WIDTH (GRP_W),
        .DEPTH (GROUPS)
    ) u_grp_state (
        .aclk  (aclk),
        .we    (grp_we),
        .waddr (grp_waddr),
        .wdata (grp_wdata),
        .raddr (grp_raddr),
        .rdata (grp_rdata)
    );

    gisa_probe u_probe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (pr_start),
        .start_p   (pr_start_p),
        .slots     (slots_reg),
        .busy      (rev_entry.valid),
        .probe_idx (probe_idx),
        .res       (pr)
    );

endmodule

// File: hdl/gisa_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; used for every map and state memory of the allocator.
`timescale 1ns / 1ps

module gisa_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 2048,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/gisa_probe.sv
// Circular free-slot probe: walks reverse-map entries one per cycle.
// Depends on gisa_pkg; the reverse map RAM sits in the top level.
`timescale 1ns / 1ps

module gisa_probe (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [gisa_pkg::ID_W-1:0]      start_p,
    input  logic [gisa_pkg::SLOTS_W-1:0]   slots,
    input  logic                           busy,
    output logic [gisa_pkg::ID_W-1:0]      probe_idx,
    output gisa_pkg::probe_res_t           res
);

    logic                           active_reg, active_next;
    logic [gisa_pkg::ID_W-1:0]      issue_p_reg, issue_p_next;
    logic [gisa_pkg::ID_W-1:0]      chk_p_reg, chk_p_next;
    logic [gisa_pkg::SLOTS_W-1:0]   chk_n_reg, chk_n_next;
    logic                           last_probe;

    // chk_p_reg is the slot whose entry is on the RAM output this cycle.
    assign last_probe = (chk_n_reg + gisa_pkg::SLOTS_W'(1)) >= slots;
    assign res.done   = active_reg && (!busy || last_probe);
    assign res.found  = active_reg && !busy;
    assign res.slot   = chk_p_reg;
    assign probe_idx  = start ? start_p : issue_p_reg;

    always_comb begin
        active_next  = active_reg;
        issue_p_next = issue_p_reg;
        chk_p_next   = chk_p_reg;
        chk_n_next   = chk_n_reg;
        if (start) begin
            active_next  = 1'b1;
            chk_p_next   = start_p;
            issue_p_next = gisa_pkg::wrap_next(start_p, slots);
            chk_n_next   = '0;
        end else if (active_reg) begin
            if (res.done) begin
                active_next = 1'b0;
            end else begin
                chk_p_next   = issue_p_reg;
                issue_p_next = gisa_pkg::wrap_next(issue_p_reg, slots);
                chk_n_next   = chk_n_reg + gisa_pkg::SLOTS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge aclk) begin
        issue_p_reg <= issue_p_next;
        chk_p_reg   <= chk_p_next;
        chk_n_reg   <= chk_n_next;
    end

endmodule

// File: hdl/gisa_checker.sv
// Port-level checks for grouped_id_slot_allocator, attached by bind.
// Depends on gisa_pkg and the top level's port list.
`timescale 1ns / 1ps

module gisa_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input gisa_pkg::out_t m_data
);

    logic [2:0] open_reg;
    logic       s_acc, m_acc;

    assign s_acc = s_valid && s_ready;
    assign m_acc = m_valid && m_ready;

    // Requests accepted but not yet delivered.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= '0;
        end else begin
            open_reg <= open_reg + 3'(s_acc) - 3'(m_acc);
        end
    end

    // Reset empties the output and starts the clearing pass.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("output or request side active right after reset");

    // Failed requests hand out no id.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != gisa_pkg::STAT_OK |-> m_data.external_id == '0)
        else $error("error result with nonzero external_id");

    // One request in work plus one in the output register at most.
    a_open_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        open_reg <= 3'd2)
        else $error("too many requests in flight");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

endmodule

bind grouped_id_slot_allocator gisa_checker u_gisa_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
